[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MDPK_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MDPK_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mdpk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpk_pkg
// shared types and constants of the pad-to-key mapper
// ----------------------------------------------------------------------------
package mdpk_pkg;

    localparam int NOTE_SLOTS = 128;
    localparam int CC_SLOTS   = 128;
    localparam int SLOT_W     = 7;

    // upper nibble of a status byte
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CC       = 4'hB;
    localparam logic [3:0] KIND_SYSTEM   = 4'hF;

    typedef enum logic [1:0] {
        CMD_MIDI    = 2'd0,
        CMD_NOTE_WR = 2'd1,
        CMD_CC_WR   = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_DATA1 = 2'd1,
        PH_DATA2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] key;
        logic [6:0] idle;
        logic [6:0] press;
    } map_entry_t;

    // a completed channel message as seen on the second data byte
    typedef struct packed {
        logic              complete;
        logic              note_on;
        logic              note_off;
        logic              cc;
        logic [SLOT_W-1:0] d1;
        logic              d2_nz;
    } parse_event_t;

endpackage

[rtl/core/midi_pad_to_key_mapper_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_pad_to_key_mapper_top
// path: stage 1 holds the table read, the output register then drives out_valid
// throughput: one item per cycle unless the output stalls; single read port per table
// reset: parser waits for a status byte, both map tables read as unmapped
// no clearing pass: a valid bit per slot is cleared at once by reset
// ----------------------------------------------------------------------------
module midi_pad_to_key_mapper_top
    import mdpk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input item channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [7:0]        midi_byte,
    input  logic [SLOT_W-1:0] slot,
    input  logic [7:0]        key_code,
    input  logic [6:0]        idle_color,
    input  logic [6:0]        pressed_color,
    // result item channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        key_out,
    output logic              pressed,
    output logic              led_is_cc,
    output logic [SLOT_W-1:0] led_index,
    output logic [6:0]        led_color
);

    // handshake and command decode
    logic         in_accept;
    logic         byte_accept;
    logic         note_wr_en;
    logic         cc_wr_en;
    logic         rd_en;
    map_entry_t   wr_entry;
    parse_event_t ev;

    // stage 1: completed message waiting on the table read data
    logic         s1_valid_reg;
    logic         s1_valid_next;
    parse_event_t s1_ev_reg;

    // table read results, aligned with stage 1
    logic         note_rd_hit;
    map_entry_t   note_rd_data;
    logic         cc_rd_hit;
    map_entry_t   cc_rd_data;

    // result selection
    logic         note_hit;
    logic         cc_hit;
    logic         down;
    map_entry_t   sel_entry;

    // output register
    logic         out_load_ok;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [7:0]   key_out_reg;
    logic         pressed_reg;
    logic         led_is_cc_reg;
    logic [SLOT_W-1:0] led_index_reg;
    logic [6:0]   led_color_reg;

    // output register can take a new value when empty or being drained
    assign out_load_ok = !out_valid_reg || !out_stall;

    // stage 1 only holds back input while its item cannot move on
    assign in_stall    = s1_valid_reg && !out_load_ok;
    assign in_accept   = in_valid && !in_stall;

    assign byte_accept = in_accept && (command == CMD_MIDI);
    assign note_wr_en  = in_accept && (command == CMD_NOTE_WR);
    assign cc_wr_en    = in_accept && (command == CMD_CC_WR);

    assign wr_entry.key   = key_code;
    assign wr_entry.idle  = idle_color;
    assign wr_entry.press = pressed_color;

    mdpk_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .midi_byte   (midi_byte),
        .ev          (ev)
    );

    // both tables are looked up on the second data byte, at the held first data byte
    assign rd_en = ev.complete;

    mdpk_map_ram #(.DEPTH(NOTE_SLOTS)) u_note_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (note_wr_en),
        .wr_slot (slot),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_slot (ev.d1),
        .rd_hit  (note_rd_hit),
        .rd_data (note_rd_data)
    );

    mdpk_map_ram #(.DEPTH(CC_SLOTS)) u_cc_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cc_wr_en),
        .wr_slot (slot),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_slot (ev.d1),
        .rd_hit  (cc_rd_hit),
        .rd_data (cc_rd_data)
    );

    // stage 1 loads on every accepted item, else empties into the output when it can, else holds
    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = ev.complete && (ev.note_on || ev.note_off || ev.cc);
        end
        else if (out_load_ok)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // event payload moves with the table read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_ev_reg <= ev;
        end
    end

    // a slot counts as mapped only with a non-zero key code
    assign note_hit  = (s1_ev_reg.note_on || s1_ev_reg.note_off)
                       && note_rd_hit && (note_rd_data.key != 8'd0);
    assign cc_hit    = s1_ev_reg.cc && cc_rd_hit && (cc_rd_data.key != 8'd0);
    assign sel_entry = cc_hit ? cc_rd_data : note_rd_data;

    // note-on with velocity zero and note-off are releases; cc value zero too
    assign down = cc_hit ? s1_ev_reg.d2_nz : (s1_ev_reg.note_on && s1_ev_reg.d2_nz);

    assign out_valid_next = out_load_ok ? (s1_valid_reg && (note_hit || cc_hit))
                                        : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_ok && s1_valid_reg)
        begin
            key_out_reg   <= sel_entry.key;
            pressed_reg   <= down;
            led_is_cc_reg <= cc_hit;
            led_index_reg <= s1_ev_reg.d1;
            led_color_reg <= down ? sel_entry.press : sel_entry.idle;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign pressed   = pressed_reg;
    assign led_is_cc = led_is_cc_reg;
    assign led_index = led_index_reg;
    assign led_color = led_color_reg;

endmodule

[rtl/core/mdpk_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpk_parser
// running-status parser, two data bytes for every channel message
// ----------------------------------------------------------------------------
module mdpk_parser
    import mdpk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_accept,
    input  logic [7:0]   midi_byte,
    output parse_event_t ev
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [7:0]        held_status_reg;
    logic [7:0]        held_status_next;
    logic [SLOT_W-1:0] held_first_reg;
    logic [SLOT_W-1:0] held_first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            held_status_reg <= 8'd0;
            held_first_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            held_status_reg <= held_status_next;
            held_first_reg  <= held_first_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        held_status_next = held_status_reg;
        held_first_next  = held_first_reg;
        if (byte_accept)
        begin
            if (midi_byte[7])
            begin
                if (midi_byte[7:4] == KIND_SYSTEM)
                begin
                    phase_next = PH_WAIT;
                end
                else
                begin
                    phase_next       = PH_DATA1;
                    held_status_next = midi_byte;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_DATA1:
                    begin
                        phase_next      = PH_DATA2;
                        held_first_next = midi_byte[SLOT_W-1:0];
                    end
                    PH_DATA2:
                    begin
                        phase_next = PH_DATA1;
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end
    end

    // outputs
    always_comb
    begin
        ev.complete = 1'b0;
        unique case (phase_reg)
            PH_DATA2: ev.complete = byte_accept && !midi_byte[7];
            default:  ev.complete = 1'b0;
        endcase
        ev.note_on  = (held_status_reg[7:4] == KIND_NOTE_ON);
        ev.note_off = (held_status_reg[7:4] == KIND_NOTE_OFF);
        ev.cc       = (held_status_reg[7:4] == KIND_CC);
        ev.d1       = held_first_reg;
        ev.d2_nz    = |midi_byte[6:0];
    end

endmodule

[rtl/core/mdpk_map_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpk_map_ram
// slot map memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mdpk_map_ram
    import mdpk_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_slot,
    input  map_entry_t        wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_slot,
    output logic              rd_hit,
    output map_entry_t        rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    map_entry_t mem_reg [DEPTH];
    logic       valid_reg [DEPTH];
    logic       rd_hit_reg;
    map_entry_t rd_data_reg;
    logic       wr_in_range;
    logic       rd_in_range;
    logic [AW-1:0] wr_idx;
    logic [AW-1:0] rd_idx;

    assign wr_in_range = (SLOT_W+1)'(wr_slot) < (SLOT_W+1)'(DEPTH);
    assign rd_in_range = (SLOT_W+1)'(rd_slot) < (SLOT_W+1)'(DEPTH);
    assign wr_idx      = AW'(wr_slot);
    assign rd_idx      = AW'(rd_slot);

    // valid bits stand in for the cleared contents after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in_range)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= rd_in_range && valid_reg[rd_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem_reg[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_idx];
        end
    end

    assign rd_hit  = rd_hit_reg;
    assign rd_data = rd_data_reg;

endmodule

[rtl/core/mdpk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpk_checker
// port-level checks of the pad-to-key mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdpk_checker
    import mdpk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [7:0]        key_out,
    input logic              pressed,
    input logic              led_is_cc,
    input logic [SLOT_W-1:0] led_index,
    input logic [6:0]        led_color
);

    logic        out_held;
    logic [23:0] out_pl;

    assign out_held = out_valid && out_stall;
    assign out_pl   = {key_out, pressed, led_is_cc, led_index, led_color};

    // a stalled result stays offered
    `MDPK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid, "result dropped while stalled")

    // and keeps its payload
    `MDPK_ASSERT_NEXT(a_out_stable, clk, rst_n, out_held, $stable(out_pl), "result changed")

    // unmapped slots never give a result
    `MDPK_ASSERT_IMP(a_key_mapped, clk, rst_n, out_valid, key_out != 8'd0, "key code zero")

    // input backpressure only comes from a stalled full output
    `MDPK_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_held, "stall with no cause")

endmodule

bind midi_pad_to_key_mapper_top mdpk_checker u_mdpk_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_out   (key_out),
    .pressed   (pressed),
    .led_is_cc (led_is_cc),
    .led_index (led_index),
    .led_color (led_color)
);
